// ===== rtl/wsws_pkg.sv =====
package wsws_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int WINDOW_MAX = 64;
    localparam int IDX_BITS   = $clog2(WINDOW_MAX);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int PS_BITS    = 16;
    localparam int WS_BITS    = 7;
    localparam int WIN_BITS   = 32;
    localparam int BIT_BITS   = $clog2(ADDR_BITS);
    localparam int OUT_BITS   = ((CNT_BITS + WIN_BITS + 7) / 8) * 8;

    localparam logic CFG_PAGE_WORDS = 1'b0;
    localparam logic CFG_WIN_LEN    = 1'b1;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/working_set_window_sampler.sv =====
// Flush beat: after acceptance the result is loaded into the output register in ST_FINISH,
// once that register is free. Access beat: bit-serial division of the address by the
// page size, then a search of the page memory at one entry per cycle. One beat is
// processed at a time.
// Reset (aresetn low, synchronous) clears the set, window position, window counter
// and output valid; the page size returns to 1 and the window length to 64.
module working_set_window_sampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // address
    input  logic [wsws_pkg::ADDR_BITS-1:0]    s_tdata,
    // func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // page count [6:0], window index [38:7], zero fill above
    output logic [wsws_pkg::OUT_BITS-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [wsws_pkg::PS_BITS-1:0]      cfg_data
);
    import wsws_pkg::*;

    state_t                 state_reg, state_next;
    logic [PS_BITS-1:0]     page_words_reg;
    logic [WS_BITS-1:0]     win_len_reg;
    logic [ADDR_BITS-1:0]   div_reg, div_next;
    logic [PS_BITS-1:0]     rem_reg, rem_next;
    logic [BIT_BITS-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [CNT_BITS-1:0]    set_count_reg, set_count_next;
    logic [IDX_BITS-1:0]    position_reg, position_next;
    logic [WIN_BITS-1:0]    windows_reg, windows_next;
    logic [CNT_BITS-1:0]    issue_idx_reg, issue_idx_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [ADDR_BITS-1:0]   rdata_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [CNT_BITS-1:0]    out_pages_reg;
    logic [WIN_BITS-1:0]    out_window_reg;
    logic                   out_load;
    logic                   rd_en, wr_en;

    logic [ADDR_BITS-1:0]   page_list [WINDOW_MAX];

    logic [PS_BITS-1:0]     ps_eff;
    logic [WS_BITS-1:0]     ws_eff;
    logic [PS_BITS:0]       trial;
    logic                   qbit;
    logic                   found;
    logic [CNT_BITS-1:0]    pos_inc;

    assign ps_eff = (page_words_reg == '0) ? PS_BITS'(1) : page_words_reg;

    always_comb begin
        if (win_len_reg == '0) begin
            ws_eff = WS_BITS'(1);
        end else if (win_len_reg > WS_BITS'(WINDOW_MAX)) begin
            ws_eff = WS_BITS'(WINDOW_MAX);
        end else begin
            ws_eff = win_len_reg;
        end
    end

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, div_reg[ADDR_BITS-1]};
    assign qbit  = (trial >= {1'b0, ps_eff});
    assign found = rd_valid_reg && (rdata_reg == div_reg);
    assign pos_inc = {1'b0, position_reg} + CNT_BITS'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_BITS'({out_window_reg, out_pages_reg});

    always_comb begin
        state_next     = state_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        set_count_next = set_count_reg;
        position_next  = position_reg;
        windows_next   = windows_reg;
        issue_idx_next = issue_idx_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == FUNC_FLUSH) begin
                        state_next = ST_FINISH;
                    end else begin
                        div_next     = s_tdata;
                        rem_next     = '0;
                        bit_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (qbit) begin
                    rem_next = PS_BITS'(trial - {1'b0, ps_eff});
                end else begin
                    rem_next = trial[PS_BITS-1:0];
                end
                div_next     = {div_reg[ADDR_BITS-2:0], qbit};
                bit_cnt_next = bit_cnt_reg + BIT_BITS'(1);
                if (bit_cnt_reg == BIT_BITS'(ADDR_BITS - 1)) begin
                    issue_idx_next = '0;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Reads are issued one entry per cycle; each compare sees the
                // registered data of the read issued the cycle before.
                if (found || (issue_idx_reg >= set_count_reg && !rd_valid_reg)) begin
                    if (!found && set_count_reg < CNT_BITS'(WINDOW_MAX)) begin
                        wr_en          = 1'b1;
                        set_count_next = set_count_reg + CNT_BITS'(1);
                    end
                    if (pos_inc >= CNT_BITS'(ws_eff)) begin
                        position_next = '0;
                        state_next    = ST_FINISH;
                    end else begin
                        position_next = pos_inc[IDX_BITS-1:0];
                        state_next    = ST_IDLE;
                    end
                end else if (issue_idx_reg < set_count_reg) begin
                    rd_en          = 1'b1;
                    rd_valid_next  = 1'b1;
                    issue_idx_next = issue_idx_reg + CNT_BITS'(1);
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    windows_next   = windows_reg + WIN_BITS'(1);
                    set_count_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            page_words_reg  <= PS_BITS'(1);
            win_len_reg     <= WS_BITS'(WINDOW_MAX);
            set_count_reg   <= '0;
            position_reg    <= '0;
            windows_reg     <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            bit_cnt_reg     <= '0;
            issue_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            set_count_reg <= set_count_next;
            position_reg  <= position_next;
            windows_reg   <= windows_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            issue_idx_reg <= issue_idx_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PAGE_WORDS) begin
                    page_words_reg <= cfg_data;
                end else begin
                    win_len_reg <= cfg_data[WS_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        if (out_load) begin
            out_pages_reg  <= set_count_reg;
            out_window_reg <= windows_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            page_list[set_count_reg[IDX_BITS-1:0]] <= div_reg;
        end
        if (rd_en) begin
            rdata_reg <= page_list[issue_idx_reg[IDX_BITS-1:0]];
        end
    end

    a_set_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        set_count_reg <= CNT_BITS'(WINDOW_MAX))
        else $error("set count exceeds the page memory depth");

    a_flush_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FUNC_FLUSH) |=> state_reg == ST_FINISH)
        else $error("flush beat did not go straight to result");

    a_window_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> windows_reg == $past(windows_reg) + WIN_BITS'(1))
        else $error("window counter did not advance with a result");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (set_count_reg < CNT_BITS'(WINDOW_MAX) && !found))
        else $error("page stored into a full set or already present");

endmodule
